// ===== rtl/button_debounce_auto_repeat_defines.svh =====
// Assertion macros shared by the debounce block.
// Depends on nothing; the asserting module must have clk_i and rst_ni.
`ifndef BUTTON_DEBOUNCE_AUTO_REPEAT_DEFINES_SVH
`define BUTTON_DEBOUNCE_AUTO_REPEAT_DEFINES_SVH

// Clocked property, switched off while reset is applied.
`define BDAR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must hold at every clock edge out of reset.
`define BDAR_ASSERT_ALWAYS(label, expr, msg) \
  `BDAR_ASSERT(label, 1'b1 |-> (expr), msg)

`endif

// ===== rtl/bdar_pkg.sv =====
// Package of the button debounce block: widths, reset values, register codes,
// the threshold struct for the lanes and the lane result struct for the merge stage.
`default_nettype none
package bdar_pkg;

  localparam int NUM_BUTTONS_DEF = 6;
  localparam int CNT_W           = 16;
  localparam int CFG_W           = 16;
  localparam int CFG_IDX_W       = 2;

  localparam logic [CNT_W-1:0] DEBOUNCE_RST = 16'd50;
  localparam logic [CNT_W-1:0] DELAY_RST    = 16'd300;
  localparam logic [CNT_W-1:0] INTERVAL_RST = 16'd300;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_DELAY    = 2'd1,
    CFG_INTERVAL = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [CNT_W-1:0] debounce;
    logic [CNT_W-1:0] delay;
    logic [CNT_W-1:0] interval;
  } cfg_t;

  // What one lane found on the current tick.
  typedef struct packed {
    logic ev;
    logic kind;
  } lane_res_t;

endpackage
`default_nettype wire

// ===== rtl/bdar_tick_if.sv =====
// Channel carrying one tick item: the raw active-low button sample.
// Depends on nothing.
`default_nettype none
interface bdar_tick_if #(
  parameter int NUM_BUTTONS = 6
);
  logic                   valid;
  logic                   ready;
  logic [NUM_BUTTONS-1:0] raw_buttons;

  modport source (output valid, output raw_buttons, input ready);
  modport sink   (input valid, input raw_buttons, output ready);
endinterface
`default_nettype wire

// ===== rtl/bdar_event_if.sv =====
// Channel carrying one event item: button, press/release and last marker.
// Depends on nothing.
`default_nettype none
interface bdar_event_if #(
  parameter int IDX_W = 3
);
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] button_index;
  logic             event_kind;
  logic             last_event;

  modport source (output valid, output button_index, output event_kind,
                  output last_event, input ready);
  modport sink   (input valid, input button_index, input event_kind,
                  input last_event, output ready);
endinterface
`default_nettype wire

// ===== rtl/bdar_lane.sv =====
// One button lane: stable level, repeat flag and saturating tick counter.
// Depends on bdar_pkg.
`default_nettype none
module bdar_lane import bdar_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      tick_i,
  input  wire logic      raw_i,
  input  wire cfg_t      cfg_i,
  output lane_res_t      res_o
);

  logic             stable_q, stable_d;
  logic             rep_q, rep_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic             chg;
  logic             rpt;
  logic             rep_a;
  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] cnt_a;

  always_comb begin
    cnt_inc  = (&cnt_q) ? cnt_q : cnt_q + 1'b1;
    chg      = (raw_i != stable_q) && (cnt_inc >= cfg_i.debounce);
    stable_d = chg ? raw_i : stable_q;
    rep_a    = (chg && raw_i) ? 1'b0 : rep_q;
    cnt_a    = chg ? '0 : cnt_inc;
    rep_d    = rep_a;
    cnt_d    = cnt_a;
    rpt      = 1'b0;
    // A held button first arms repeating silently, then repeats on the interval.
    if (!stable_d) begin
      if (!rep_a) begin
        if (cnt_a >= cfg_i.delay) begin
          rep_d = 1'b1;
          cnt_d = '0;
        end
      end else if (cnt_a >= cfg_i.interval) begin
        rpt   = 1'b1;
        cnt_d = '0;
      end
    end
    res_o.ev   = chg | rpt;
    res_o.kind = chg & raw_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q <= 1'b1;
      rep_q    <= 1'b0;
      cnt_q    <= '0;
    end else if (tick_i) begin
      stable_q <= stable_d;
      rep_q    <= rep_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/bdar_merge.sv =====
// Merge stage: collects the lane events of one tick and hands them out one
// item per cycle while the receiver is ready, in button order. Depends on
// bdar_pkg, bdar_event_if and the assertion macro header.
`default_nettype none
`include "button_debounce_auto_repeat_defines.svh"
module bdar_merge import bdar_pkg::*; #(
  parameter int NUM_BUTTONS = NUM_BUTTONS_DEF,
  parameter int IDX_W       = 3
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire lane_res_t res_i [NUM_BUTTONS],
  bdar_event_if.source   evt
);

  logic [NUM_BUTTONS-1:0] pend_q, pend_d;
  logic [NUM_BUTTONS-1:0] kind_q;
  logic [NUM_BUTTONS-1:0] ev_mask;
  logic [NUM_BUTTONS-1:0] kind_mask;
  logic [NUM_BUTTONS-1:0] low_bit;
  logic [NUM_BUTTONS-1:0] rest;
  logic [NUM_BUTTONS-1:0] below_mask;
  logic [IDX_W-1:0]       sel_idx;
  logic                   found;
  logic                   out_valid_q;
  logic [IDX_W-1:0]       out_idx_q;
  logic                   out_kind_q;
  logic                   out_last_q;
  logic                   out_load;
  logic                   in_acc;

  always_comb begin
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      ev_mask[i]    = res_i[i].ev;
      kind_mask[i]  = res_i[i].kind;
      below_mask[i] = (i <= int'(out_idx_q));
    end
    sel_idx = '0;
    found   = 1'b0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (pend_q[i] && !found) begin
        sel_idx = IDX_W'(i);
        found   = 1'b1;
      end
    end
    low_bit  = pend_q & (~pend_q + 1'b1);
    rest     = pend_q & ~low_bit;
    out_load = (pend_q != '0) && (!out_valid_q || evt.ready);
    // A new tick is taken once the previous tick's events have all left the
    // pending mask, which may happen in this very cycle.
    in_ready_o = (pend_q == '0) || (out_load && (rest == '0));
    in_acc     = in_valid_i && in_ready_o;
    pend_d     = pend_q;
    if (out_load) begin
      pend_d = rest;
    end
    if (in_acc) begin
      pend_d = ev_mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (evt.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q <= kind_mask;
    end
    if (out_load) begin
      out_idx_q  <= sel_idx;
      out_kind_q <= kind_q[sel_idx];
      out_last_q <= (rest == '0);
    end
  end

  assign evt.valid        = out_valid_q;
  assign evt.button_index = out_idx_q;
  assign evt.event_kind   = out_kind_q;
  assign evt.last_event   = out_last_q;

  `BDAR_ASSERT(a_more_after_not_last, out_valid_q && !out_last_q |-> pend_q != '0, "event not marked last but nothing pending")
  `BDAR_ASSERT(a_order_kept, out_valid_q && !out_last_q |-> (pend_q & below_mask) == '0, "pending event at or below the shown button")
  `BDAR_ASSERT(a_pending_shown, (pend_q != '0) |=> out_valid_q, "pending events but no item offered")

endmodule
`default_nettype wire

// ===== rtl/button_debounce_auto_repeat.sv =====
// Button debounce with auto-repeat. All lanes update together on an accepted
// tick; its events (at most NUM_BUTTONS) pass through the pending mask and the
// single event output register, one per cycle while the receiver is ready.
// Ticks: one per cycle while no events are pending, else once the last pending event loads.
// Reset (asynchronous, active low): all buttons released, no repeating,
// counters zero, thresholds 50, 300 and 300 ticks.
`default_nettype none
module button_debounce_auto_repeat import bdar_pkg::*; #(
  parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  bdar_tick_if.sink                 tick_i,
  bdar_event_if.source              evt_o
);

  localparam int IdxW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  cfg_t      cfg_q;
  lane_res_t res [NUM_BUTTONS];
  logic      tick_acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce <= DEBOUNCE_RST;
      cfg_q.delay    <= DELAY_RST;
      cfg_q.interval <= INTERVAL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_DEBOUNCE: cfg_q.debounce <= cfg_data_i;
        CFG_DELAY:    cfg_q.delay    <= cfg_data_i;
        CFG_INTERVAL: cfg_q.interval <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign tick_acc = tick_i.valid && tick_i.ready;

  for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
    bdar_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tick_i (tick_acc),
      .raw_i  (tick_i.raw_buttons[g]),
      .cfg_i  (cfg_q),
      .res_o  (res[g])
    );
  end

  bdar_merge #(
    .NUM_BUTTONS (NUM_BUTTONS),
    .IDX_W       (IdxW)
  ) u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (tick_i.valid),
    .in_ready_o (tick_i.ready),
    .res_i      (res),
    .evt        (evt_o)
  );

endmodule
`default_nettype wire

// ===== tb/bdar_event_checker.sv =====
// Event checker for the button debounce block: predicts the events of every
// accepted tick and compares them with the event items that leave the block.
// Depends on bdar_pkg for widths, register codes and reset thresholds.
module bdar_event_checker import bdar_pkg::*; #(
  parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   tick_valid_i,
  input  logic                   tick_ready_i,
  input  logic [NUM_BUTTONS-1:0] raw_buttons_i,
  input  logic                   evt_valid_i,
  input  logic                   evt_ready_i,
  input  logic [2:0]             button_index_i,
  input  logic                   event_kind_i,
  input  logic                   last_event_i,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_data_i,
  output int                     fail_count_o,
  output int                     pending_o
);

  typedef struct packed {
    logic [2:0] button_index;
    logic       event_kind;
    logic       last_event;
  } btn_event_t;

  localparam logic [CNT_W-1:0] COUNT_SAT = '1;

  cfg_t                   thresholds;
  logic [NUM_BUTTONS-1:0] released;
  logic [NUM_BUTTONS-1:0] repeating;
  logic [CNT_W-1:0]       since_event [NUM_BUTTONS];
  btn_event_t             awaited_events [$];
  btn_event_t             oldest;
  int                     mismatches = 0;

  assign fail_count_o = mismatches;

  // Advances every button by one tick and queues the events it raises.
  task automatic advance_tick(input logic [NUM_BUTTONS-1:0] raw);
    logic [NUM_BUTTONS-1:0] fired;
    logic [NUM_BUTTONS-1:0] kinds;
    btn_event_t             ev;
    fired = '0;
    kinds = '0;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      if (since_event[b] != COUNT_SAT) since_event[b] = since_event[b] + 1'b1;
      if (raw[b] != released[b] && since_event[b] >= thresholds.debounce) begin
        fired[b]       = 1'b1;
        since_event[b] = '0;
        released[b]    = raw[b];
        kinds[b]       = raw[b];
        if (raw[b]) repeating[b] = 1'b0;
      end
      // A held button first waits out the delay silently, then repeats.
      if (!released[b]) begin
        if (!repeating[b]) begin
          if (since_event[b] >= thresholds.delay) begin
            repeating[b]   = 1'b1;
            since_event[b] = '0;
          end
        end else if (since_event[b] >= thresholds.interval) begin
          fired[b]       = 1'b1;
          kinds[b]       = 1'b0;
          since_event[b] = '0;
        end
      end
    end
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      if (fired[b]) begin
        ev.button_index = 3'(b);
        ev.event_kind   = kinds[b];
        ev.last_event   = ((fired >> (b + 1)) == '0);
        awaited_events.push_back(ev);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresholds.debounce = DEBOUNCE_RST;
      thresholds.delay    = DELAY_RST;
      thresholds.interval = INTERVAL_RST;
      released            = '1;
      repeating           = '0;
      foreach (since_event[b]) since_event[b] = '0;
      awaited_events.delete();
      pending_o <= 0;
    end else begin
      if (evt_valid_i && evt_ready_i) begin
        if (awaited_events.size() == 0) begin
          $error("unexpected event item: button_index %0d event_kind %0d last_event %0d",
                 button_index_i, event_kind_i, last_event_i);
          mismatches++;
        end else begin
          oldest = awaited_events.pop_front();
          if (button_index_i !== oldest.button_index) begin
            $error("button_index: expected %0d, got %0d", oldest.button_index, button_index_i);
            mismatches++;
          end
          if (event_kind_i !== oldest.event_kind) begin
            $error("event_kind: expected %0d, got %0d", oldest.event_kind, event_kind_i);
            mismatches++;
          end
          if (last_event_i !== oldest.last_event) begin
            $error("last_event: expected %0d, got %0d", oldest.last_event, last_event_i);
            mismatches++;
          end
        end
      end
      if (tick_valid_i && tick_ready_i) advance_tick(raw_buttons_i);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DEBOUNCE: thresholds.debounce = cfg_data_i;
          CFG_DELAY:    thresholds.delay    = cfg_data_i;
          CFG_INTERVAL: thresholds.interval = cfg_data_i;
          default: ;  // The spare index has no register behind it.
        endcase
      end
      pending_o <= awaited_events.size();
    end
  end

endmodule

// ===== tb/button_debounce_auto_repeat_test.sv =====
// Top of the button debounce testbench: clock, reset, tick stimulus, threshold
// programming, receiver stalls and the verdict. Depends on bdar_pkg, the two
// channel interfaces, the block itself and bdar_event_checker.
module button_debounce_auto_repeat_test;
  import bdar_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int SETTLE_CYCLES   = 8;
  localparam int IDLE_LIMIT      = 4000;
  localparam int SOAK_TICKS      = 20;
  localparam int TICKS_PER_PHASE = 45;
  localparam logic [5:0] ZERO_THRESHOLD_TICKS [12] = '{
    6'h00, 6'h00, 6'h00, 6'h3f, 6'h2a, 6'h15,
    6'h2a, 6'h3f, 6'h3e, 6'h3c, 6'h00, 6'h3f
  };

  logic                 clk;
  logic                 rst_n    = 1'b0;
  logic                 cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx  = CFG_DEBOUNCE;
  logic [CFG_W-1:0]     cfg_data = '0;
  int                   gap_pct     = 0;
  int                   stall_pct   = 0;
  int                   idle_cycles = 0;
  int                   fail_count;
  int                   pending;

  bdar_tick_if  #(.NUM_BUTTONS(NUM_BUTTONS_DEF)) tick_ch ();
  bdar_event_if #(.IDX_W(3))                     evt_ch ();

  button_debounce_auto_repeat #(
    .NUM_BUTTONS(NUM_BUTTONS_DEF)
  ) dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .tick_i    (tick_ch.sink),
    .evt_o     (evt_ch.source)
  );

  bdar_event_checker #(
    .NUM_BUTTONS(NUM_BUTTONS_DEF)
  ) checker_i (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .tick_valid_i  (tick_ch.valid),
    .tick_ready_i  (tick_ch.ready),
    .raw_buttons_i (tick_ch.raw_buttons),
    .evt_valid_i   (evt_ch.valid),
    .evt_ready_i   (evt_ch.ready),
    .button_index_i(evt_ch.button_index),
    .event_kind_i  (evt_ch.event_kind),
    .last_event_i  (evt_ch.last_event),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    evt_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      evt_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Ends a run that has stopped moving items in either direction.
  always @(posedge clk) begin
    if ((tick_ch.valid && tick_ch.ready) || (evt_ch.valid && evt_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IDLE_LIMIT) begin
      $display("button_debounce_auto_repeat_test: done, errors");
      $finish;
    end
  end

  // Valid is left high on return so that back-to-back ticks need no gap.
  task automatic push_tick(input logic [5:0] raw);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      tick_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < gap_pct);
    end
    tick_ch.valid       <= 1'b1;
    tick_ch.raw_buttons <= raw;
    do @(posedge clk); while (!tick_ch.ready);
  endtask

  task automatic drain_events();
    tick_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_cfg(input logic [CFG_W-1:0] debounce, input logic [CFG_W-1:0] delay,
                             input logic [CFG_W-1:0] interval);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_DEBOUNCE;
    cfg_data <= debounce;
    @(posedge clk);
    cfg_idx  <= CFG_DELAY;
    cfg_data <= delay;
    @(posedge clk);
    cfg_idx  <= CFG_INTERVAL;
    cfg_data <= interval;
    @(posedge clk);
    cfg_idx  <= CFG_SPARE;
    cfg_data <= 16'($urandom);
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  initial begin
    logic [5:0] intent;
    logic [5:0] noise;
    logic [5:0] raw;
    tick_ch.valid       = 1'b0;
    tick_ch.raw_buttons = '1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset thresholds: nothing may be accepted this early.
    push_tick(6'h00);
    push_tick(6'h15);
    push_tick(6'h3f);

    drain_events();
    program_cfg(16'd0, 16'd0, 16'd0);
    foreach (ZERO_THRESHOLD_TICKS[i]) push_tick(ZERO_THRESHOLD_TICKS[i]);

    // With the largest thresholds no change is accepted in a short stretch,
    // not even all six buttons pressed at once.
    drain_events();
    program_cfg('1, '1, '1);
    repeat (SOAK_TICKS) push_tick(6'h3f);
    push_tick(6'h00);
    push_tick(6'h3f);

    intent = '1;
    for (int p = 0; p < 4; p++) begin
      drain_events();
      case (p)
        0: program_cfg(16'd1, 16'd3, 16'd2);
        1: program_cfg(16'($urandom_range(0, 3)), 16'($urandom_range(0, 10)),
                       16'($urandom_range(0, 5)));
        2: program_cfg(16'd2, 16'd0, 16'd1);
        default: program_cfg(16'd0, 16'd6, 16'd0);
      endcase
      gap_pct   = (p == 1) ? 64 : (p == 3) ? 36 : 0;
      stall_pct = (p == 2) ? 64 : (p == 3) ? 36 : 0;
      for (int n = 0; n < TICKS_PER_PHASE; n++) begin
        // Mostly held or released buttons with the odd bounce on top.
        noise = '0;
        for (int b = 0; b < 6; b++) begin
          if ($urandom_range(0, 9) == 0) intent[b] = ~intent[b];
          if ($urandom_range(0, 11) == 0) noise[b] = 1'b1;
        end
        raw = ($urandom_range(0, 19) == 0) ? 6'($urandom) : (intent ^ noise);
        push_tick(raw);
        if ((p == 1 && n == TICKS_PER_PHASE / 2) || $urandom_range(0, 24) == 0) drain_events();
      end
    end

    drain_events();
    if (fail_count == 0 && pending == 0) begin
      $display("button_debounce_auto_repeat_test: done, clean");
    end else begin
      $display("button_debounce_auto_repeat_test: done, errors");
    end
    $finish;
  end

endmodule
